[rtl/cmpt_pkg.sv]
// Shared types, constants and register map of the color matrix transform.
package cmpt_pkg;

  localparam int DATA_W       = 8;
  localparam int COEF_W       = 16;
  localparam int OFS_W        = 16;
  localparam int CFG_W        = 64;
  localparam int CFG_IDX_W    = 3;
  localparam int MAX_CHANNELS = 4;

  localparam int COEF_FRAC_BITS_DEF = 12;
  localparam int NUM_CHANNELS_DEF   = 4;

  // Diagonal weight loaded at reset.
  localparam logic [COEF_W-1:0] RESET_DIAG_COEF = 16'd4096;
  localparam logic [CFG_W-1:0]  RESET_OFFSETS   = 64'd0;

  localparam logic [DATA_W-1:0] LEVEL_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFS_OUT0      = 3'd0,
    REG_COEFS_OUT1      = 3'd1,
    REG_COEFS_OUT2      = 3'd2,
    REG_COEFS_OUT3      = 3'd3,
    REG_CHANNEL_OFFSETS = 3'd4
  } reg_idx_t;

  typedef logic [CFG_W-1:0] cfg_word_t;
  typedef logic [MAX_CHANNELS-1:0][DATA_W-1:0] pixel_t;

  typedef struct packed {
    cfg_word_t [MAX_CHANNELS-1:0] coefs;
    cfg_word_t                    offsets;
  } cfg_t;

endpackage

[rtl/cmpt_if.sv]
// Valid/ready stream interfaces for input and corrected pixels.
interface cmpt_in_if;
  logic                      valid;
  logic                      ready;
  logic [cmpt_pkg::DATA_W-1:0] in_ch0;
  logic [cmpt_pkg::DATA_W-1:0] in_ch1;
  logic [cmpt_pkg::DATA_W-1:0] in_ch2;
  logic [cmpt_pkg::DATA_W-1:0] in_ch3;

  modport source (output valid, output in_ch0, output in_ch1, output in_ch2,
                  output in_ch3, input ready);
  modport sink   (input valid, input in_ch0, input in_ch1, input in_ch2,
                  input in_ch3, output ready);
endinterface

interface cmpt_out_if;
  logic                      valid;
  logic                      ready;
  logic [cmpt_pkg::DATA_W-1:0] out_ch0;
  logic [cmpt_pkg::DATA_W-1:0] out_ch1;
  logic [cmpt_pkg::DATA_W-1:0] out_ch2;
  logic [cmpt_pkg::DATA_W-1:0] out_ch3;

  modport source (output valid, output out_ch0, output out_ch1, output out_ch2,
                  output out_ch3, input ready);
  modport sink   (input valid, input out_ch0, input out_ch1, input out_ch2,
                  input out_ch3, output ready);
endinterface

[rtl/cmpt_cfg_regs.sv]
// Configuration register file: four weight words and the offset word.
module cmpt_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cmpt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [cmpt_pkg::CFG_W-1:0]     cfg_wdata,
  output cmpt_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < cmpt_pkg::MAX_CHANNELS; c++) begin
        cfg.coefs[c] <= cmpt_pkg::CFG_W'(cmpt_pkg::RESET_DIAG_COEF) << (cmpt_pkg::COEF_W * c);
      end
      cfg.offsets <= cmpt_pkg::RESET_OFFSETS;
    end else if (cfg_we) begin
      case (cmpt_pkg::reg_idx_t'(cfg_idx))
        cmpt_pkg::REG_COEFS_OUT0:      cfg.coefs[0] <= cfg_wdata;
        cmpt_pkg::REG_COEFS_OUT1:      cfg.coefs[1] <= cfg_wdata;
        cmpt_pkg::REG_COEFS_OUT2:      cfg.coefs[2] <= cfg_wdata;
        cmpt_pkg::REG_COEFS_OUT3:      cfg.coefs[3] <= cfg_wdata;
        cmpt_pkg::REG_CHANNEL_OFFSETS: cfg.offsets  <= cfg_wdata;
        default: ;  // drop writes to unmapped indexes
      endcase
    end
  end

endmodule

[rtl/cmpt_channel.sv]
// One output channel: weighted sum plus offset, round half to even, clamp.
module cmpt_channel #(
  parameter int COEF_FRAC_BITS = cmpt_pkg::COEF_FRAC_BITS_DEF,
  parameter int NUM_CHANNELS   = cmpt_pkg::NUM_CHANNELS_DEF
) (
  input  cmpt_pkg::pixel_t                 pix,
  input  logic [cmpt_pkg::CFG_W-1:0]       coefs,
  input  logic [cmpt_pkg::OFS_W-1:0]       offset,
  output logic [cmpt_pkg::DATA_W-1:0]      level
);

  localparam int PROD_W  = cmpt_pkg::DATA_W + 1 + cmpt_pkg::COEF_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int OFS_SH  = COEF_FRAC_BITS - 4;
  localparam int OFS_EW  = cmpt_pkg::OFS_W + OFS_SH;
  localparam int ACC_W   = ((SUM_W > OFS_EW) ? SUM_W : OFS_EW) + 1;
  localparam int Q_W     = ACC_W - COEF_FRAC_BITS;

  logic signed [PROD_W-1:0]         prod [cmpt_pkg::MAX_CHANNELS];
  logic signed [ACC_W-1:0]          acc;
  logic signed [Q_W-1:0]            q;
  logic [COEF_FRAC_BITS-1:0]        frac;
  logic                             round_up;
  logic signed [Q_W:0]              q_rnd;

  always_comb begin
    for (int k = 0; k < cmpt_pkg::MAX_CHANNELS; k++) begin
      prod[k] = $signed({1'b0, pix[k]}) *
                $signed(coefs[cmpt_pkg::COEF_W*k +: cmpt_pkg::COEF_W]);
    end
  end

  always_comb begin
    acc = $signed({{(ACC_W - cmpt_pkg::OFS_W){offset[cmpt_pkg::OFS_W-1]}}, offset}) <<< OFS_SH;
    for (int k = 0; k < cmpt_pkg::MAX_CHANNELS; k++) begin
      if (k < NUM_CHANNELS) begin
        acc = acc + ACC_W'(prod[k]);
      end
    end
  end

  // Floor part and fraction; ties go to the even neighbor.
  assign q        = acc[ACC_W-1:COEF_FRAC_BITS];
  assign frac     = acc[COEF_FRAC_BITS-1:0];
  assign round_up = frac[COEF_FRAC_BITS-1] & ((|frac[COEF_FRAC_BITS-2:0]) | q[0]);
  assign q_rnd    = $signed({q[Q_W-1], q}) + $signed({{Q_W{1'b0}}, round_up});

  always_comb begin
    if (q_rnd[Q_W]) begin
      level = '0;
    end else if (|q_rnd[Q_W-1:cmpt_pkg::DATA_W]) begin
      level = cmpt_pkg::LEVEL_MAX;
    end else begin
      level = q_rnd[cmpt_pkg::DATA_W-1:0];
    end
  end

endmodule

[rtl/color_matrix_pixel_transform.sv]
// Top level: input register, per-channel matrix datapath, result register.
//
//   port       dir  width        role
//   pix_in     in   4 x 8        pixel beat in, valid/ready
//   pix_out    out  4 x 8        corrected pixel beat out, valid/ready
//   cfg_*      in   1 + 3 + 64   register write (index 0..4)
//
// An accepted beat passes the input register, then the result register.
// One beat per cycle is sustained while the sink is ready; the input and
// result registers form a two-deep pipeline advancing on downstream ready.
// A stalled result holds, and the input register fills behind it.
// Reset (rst, synchronous) empties both stages and loads identity weights.
module color_matrix_pixel_transform #(
  parameter int COEF_FRAC_BITS = cmpt_pkg::COEF_FRAC_BITS_DEF,
  parameter int NUM_CHANNELS   = cmpt_pkg::NUM_CHANNELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  cmpt_in_if.sink                        pix_in,
  cmpt_out_if.source                     pix_out,
  input  logic                           cfg_we,
  input  logic [cmpt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [cmpt_pkg::CFG_W-1:0]     cfg_wdata
);

  cmpt_pkg::cfg_t   cfg;
  cmpt_pkg::pixel_t s1_pix;
  logic             s1_valid;
  logic             s1_adv;
  logic             out_free;
  logic             in_acc;
  logic             out_valid;
  logic [cmpt_pkg::MAX_CHANNELS-1:0][cmpt_pkg::DATA_W-1:0] level;
  logic [cmpt_pkg::MAX_CHANNELS-1:0][cmpt_pkg::DATA_W-1:0] out_level;

  cmpt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  for (genvar c = 0; c < cmpt_pkg::MAX_CHANNELS; c++) begin : g_ch
    if (c < NUM_CHANNELS) begin : g_on
      cmpt_channel #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .NUM_CHANNELS   (NUM_CHANNELS)
      ) u_ch (
        .pix    (s1_pix),
        .coefs  (cfg.coefs[c]),
        .offset (cfg.offsets[cmpt_pkg::OFS_W*c +: cmpt_pkg::OFS_W]),
        .level  (level[c])
      );
    end else begin : g_off
      assign level[c] = '0;
    end
  end

  assign out_free     = !out_valid || pix_out.ready;
  assign s1_adv       = s1_valid && out_free;
  assign pix_in.ready = !s1_valid || s1_adv;
  assign in_acc       = pix_in.valid && pix_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pix_in.ready) begin
        s1_valid <= pix_in.valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix <= {pix_in.in_ch3, pix_in.in_ch2, pix_in.in_ch1, pix_in.in_ch0};
    end
    if (s1_adv) begin
      out_level <= level;
    end
  end

  assign pix_out.valid   = out_valid;
  assign pix_out.out_ch0 = out_level[0];
  assign pix_out.out_ch1 = out_level[1];
  assign pix_out.out_ch2 = out_level[2];
  assign pix_out.out_ch3 = out_level[3];

  // A held input beat stays held until it moves to the result register.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> s1_valid)
    else $error("input stage lost a waiting beat");

  // Both stages full and the sink stalled: no new beat may enter.
  a_full_block: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !pix_out.ready |-> !pix_in.ready)
    else $error("beat accepted into a full pipeline");

  // A new result appears only from a beat that sat in the input stage.
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result produced with no beat behind it");

  // With three channels the fourth result channel stays zero.
  a_ch3_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (NUM_CHANNELS == cmpt_pkg::MAX_CHANNELS) || (out_level[3] == '0))
    else $error("unused channel carries data");

endmodule
